FILE: rtl/cdcecm_pkg.sv
// Shared types and constants for the CDC-ECM descriptor matcher.
package cdcecm_pkg;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 104;

    localparam logic [7:0] DT_IFACE     = 8'h04;
    localparam logic [7:0] DT_CS_IFACE  = 8'h24;
    localparam logic [7:0] DT_ENDPOINT  = 8'h05;
    localparam logic [7:0] CLASS_COMM   = 8'h02;
    localparam logic [7:0] CLASS_DATA   = 8'h0A;
    localparam logic [7:0] SUBCLASS_ECM = 8'h06;
    localparam logic [7:0] FUNC_UNION   = 8'h06;
    localparam logic [7:0] FUNC_ETHER   = 8'h0F;
    localparam logic [1:0] XFER_BULK    = 2'h2;
    localparam logic [7:0] NO_IFACE     = 8'hFF;
    localparam logic [7:0] CS_MIN_LEN    = 8'd3;
    localparam logic [7:0] UNION_MIN_LEN = 8'd5;
    localparam logic [7:0] ETHER_MIN_LEN = 8'd4;

    typedef struct packed {
        logic       start_of_config;
        logic [7:0] desc_len;
        logic [7:0] desc_type;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
        logic [7:0] byte_four;
        logic [7:0] byte_five;
        logic [7:0] byte_six;
    } desc_item_t;

    typedef struct packed {
        logic [7:0]  interval;
        logic [15:0] max_packet;
        logic [7:0]  address;
    } ep_rec_t;

    typedef struct packed {
        logic       ctrl_found;
        logic       in_control_iface;
        logic       in_data_iface;
        logic       have_in_ep;
        logic       have_out_ep;
        logic       walk_stopped;
        logic [7:0] ctrl_iface_num;
        logic [7:0] data_iface_num;
        logic [7:0] data_alt_num;
        logic [7:0] mac_str_idx;
        logic [7:0] current_alt;
        ep_rec_t    in_ep;
        ep_rec_t    out_ep;
    } walk_state_t;

    typedef struct packed {
        logic       complete;
        logic       walk_done;
        logic [7:0] ctrl_iface;
        logic [7:0] data_iface;
        logic [7:0] data_alt_setting;
        logic [7:0] mac_string_index;
        ep_rec_t    in_ep;
        ep_rec_t    out_ep;
    } match_result_t;

endpackage

FILE: rtl/cdcecm_walker.sv
// Descriptor walking state and its per-descriptor update logic.
module cdcecm_walker
    import cdcecm_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  desc_item_t    item,
    output match_result_t result
);

    walk_state_t state_reg;
    walk_state_t state_next;
    walk_state_t base;
    ep_rec_t     rec;

    always_comb begin
        base = item.start_of_config ? '0 : state_reg;
        state_next = base;
        rec.address    = item.byte_two;
        rec.max_packet = {item.byte_five, item.byte_four};
        rec.interval   = item.byte_six;
        if (!base.walk_stopped) begin
            unique case (item.desc_type)
                DT_IFACE: begin
                    if (base.have_in_ep && base.have_out_ep) begin
                        state_next.walk_stopped = 1'b1;
                    end else begin
                        state_next.have_in_ep = 1'b0;
                        state_next.have_out_ep = 1'b0;
                        state_next.in_control_iface = (item.byte_five == CLASS_COMM)
                                                   && (item.byte_six == SUBCLASS_ECM);
                        state_next.in_data_iface = base.ctrl_found
                                                && (item.byte_five == CLASS_DATA)
                                                && (item.byte_two == base.data_iface_num);
                        if (state_next.in_control_iface) begin
                            state_next.ctrl_found = 1'b1;
                            state_next.ctrl_iface_num = item.byte_two;
                            state_next.data_iface_num = NO_IFACE;
                        end
                        state_next.current_alt = item.byte_three;
                    end
                end
                DT_CS_IFACE: begin
                    if (base.in_control_iface && item.desc_len >= CS_MIN_LEN) begin
                        if (item.byte_two == FUNC_UNION && item.desc_len >= UNION_MIN_LEN) begin
                            state_next.data_iface_num = item.byte_four;
                        end
                        if (item.byte_two == FUNC_ETHER && item.desc_len >= ETHER_MIN_LEN) begin
                            state_next.mac_str_idx = item.byte_three;
                        end
                    end
                end
                DT_ENDPOINT: begin
                    if (base.in_data_iface && item.byte_three[1:0] == XFER_BULK) begin
                        if (item.byte_two[7]) begin
                            state_next.in_ep = rec;
                            state_next.have_in_ep = 1'b1;
                        end else begin
                            state_next.out_ep = rec;
                            state_next.have_out_ep = 1'b1;
                        end
                        state_next.data_alt_num = base.current_alt;
                        if (state_next.have_in_ep && state_next.have_out_ep) begin
                            state_next.walk_stopped = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (step) begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        result.complete = state_next.ctrl_found && state_next.have_in_ep
                       && state_next.have_out_ep;
        result.walk_done        = state_next.walk_stopped;
        result.ctrl_iface       = state_next.ctrl_iface_num;
        result.data_iface       = state_next.data_iface_num;
        result.data_alt_setting = state_next.data_alt_num;
        result.mac_string_index = state_next.mac_str_idx;
        result.in_ep            = state_next.in_ep;
        result.out_ep           = state_next.out_ep;
    end

endmodule

FILE: rtl/cdc_ecm_descriptor_matcher.sv
// Top level of the CDC-ECM descriptor matcher: input and result registers.
//
//  channel | ports                      | carries
//  --------+----------------------------+------------------------------------
//  input   | s_tvalid s_tready s_tdata  | one descriptor, start flag on tuser
//          | s_tuser                    |
//  result  | m_tvalid m_tready m_tdata  | match status after that descriptor
//
// One descriptor per cycle unless the result stalls; each passes both registers.
// The walking state is updated as an item moves from the input register to
// the result register, so the next item sees it the following cycle.
// aresetn clears the walking state and both valid flags.
// A stalled result holds; the input register still fills behind it.
module cdc_ecm_descriptor_matcher
    import cdcecm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // desc_len, desc_type, byte_two, byte_three, byte_four, byte_five, byte_six
    input  logic [S_TDATA_W-1:0] s_tdata,
    // start_of_config
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // complete, walk_done, ctrl_iface, data_iface, data_alt_setting,
    // mac_string_index, in_ep_address, out_ep_address, in_max_packet,
    // out_max_packet, in_interval, out_interval, zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic          in_valid_reg;
    desc_item_t    in_item_reg;
    logic          out_valid_reg;
    match_result_t out_res_reg;
    match_result_t res_next;
    logic          advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.start_of_config <= s_tuser;
            in_item_reg.desc_len        <= s_tdata[7:0];
            in_item_reg.desc_type       <= s_tdata[15:8];
            in_item_reg.byte_two        <= s_tdata[23:16];
            in_item_reg.byte_three      <= s_tdata[31:24];
            in_item_reg.byte_four       <= s_tdata[39:32];
            in_item_reg.byte_five       <= s_tdata[47:40];
            in_item_reg.byte_six        <= s_tdata[55:48];
        end
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    cdcecm_walker u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .result  (res_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0,
                       out_res_reg.out_ep.interval,
                       out_res_reg.in_ep.interval,
                       out_res_reg.out_ep.max_packet,
                       out_res_reg.in_ep.max_packet,
                       out_res_reg.out_ep.address,
                       out_res_reg.in_ep.address,
                       out_res_reg.mac_string_index,
                       out_res_reg.data_alt_setting,
                       out_res_reg.data_iface,
                       out_res_reg.ctrl_iface,
                       out_res_reg.walk_done,
                       out_res_reg.complete};

endmodule
